// ===== rtl/scsr_pkg.sv =====
// Shared types and constants for the setpoint clamp / slew / raw convert unit.
// Used by scsr_ctrl, scsr_dp and the top level; no dependencies.
`default_nettype none

package scsr_pkg;

    // Q16.16 one
    localparam logic signed [31:0] QOne = 32'sd65536;

    // Quotient bits produced by the divider; larger quotients saturate
    localparam int DivBits = 42;
    localparam int CntW    = $clog2(DivBits);

    // Rounded magnitude ceiling, 2^40
    localparam logic [40:0] QMax = 41'd1 << 40;

    // Raw output saturation bounds
    localparam logic signed [42:0] RawMax = 43'sd2147483647;
    localparam logic signed [42:0] RawMin = -43'sd2147483648;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DRIVE_HIGH = 3'd0,
        CFG_DRIVE_LOW  = 3'd1,
        CFG_RATE_LIMIT = 3'd2,
        CFG_ENG_SLOPE  = 3'd3,
        CFG_ENG_OFFSET = 3'd4,
        CFG_ADJ_SLOPE  = 3'd5,
        CFG_ADJ_OFFSET = 3'd6,
        CFG_RAW_OFFSET = 3'd7
    } cfg_idx_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLEW,
        ST_MUL_OFF,
        ST_MUL_ADJ,
        ST_PREP,
        ST_MAG,
        ST_CHECK,
        ST_DIV,
        ST_ROUND,
        ST_OUT
    } state_t;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic load_in;   // capture and clamp the setpoint
        logic slew;      // rate limit, update kept output
        logic mul_off;   // eng_slope * adj_offset
        logic mul_adj;   // eng_slope * adj_slope
        logic prep;      // build numerator and denominator
        logic mag;       // magnitudes and quotient sign
        logic check;     // overflow precheck, divider init
        logic div_step;  // one restoring divide step
        logic round;     // round half away, clamp magnitude
        logic load_out;  // sign, subtract raw offset, saturate, load result
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/scsr_ctrl.sv =====
// Controller state machine for the setpoint clamp / slew / raw convert unit.
// Sequences the datapath through scsr_pkg::cmd_t and owns the handshakes.
`default_nettype none

module scsr_ctrl
    import scsr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd
);

    state_t            state_reg, state_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    // State, divide counter and result flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SLEW;
                end
            end
            ST_SLEW: begin
                cmd.slew   = 1'b1;
                state_next = ST_MUL_OFF;
            end
            ST_MUL_OFF: begin
                cmd.mul_off = 1'b1;
                state_next  = ST_MUL_ADJ;
            end
            ST_MUL_ADJ: begin
                cmd.mul_adj = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivBits - 1)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the result slot to be free or draining
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result slot: set on load, cleared on transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // A result is never loaded over one that is still held
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a held result");

    // An accepted item always starts at the slew step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SLEW))
        else $error("accepted item did not start processing");

    // Divide step count stays within the quotient width
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < CntW'(DivBits)))
        else $error("divide counter out of range");

    // Divider always runs its full length before rounding
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(cmd.round) |-> $past(cmd.div_step) && $past(cnt_reg) == CntW'(DivBits - 1))
        else $error("rounding entered before divide finished");

endmodule

`default_nettype wire

// ===== rtl/scsr_dp.sv =====
// Datapath for the setpoint clamp / slew / raw convert unit: configuration
// registers, clamp, slew limit, shared multiplier, restoring divider, rounding.
// Uses scsr_pkg; driven by commands from scsr_ctrl.
`default_nettype none

module scsr_dp
    import scsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    input  wire logic [31:0] set_value,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic [31:0]      clamped_value,
    output logic [31:0]      output_value,
    output logic             output_changed,
    output logic [31:0]      raw_value
);

    // Configuration registers
    logic signed [31:0] drive_high_reg, drive_low_reg;
    logic        [30:0] rate_limit_reg;
    logic signed [31:0] eng_slope_reg, eng_offset_reg;
    logic signed [31:0] adj_slope_reg, adj_offset_reg;
    logic signed [31:0] raw_offset_reg;

    // Kept output
    logic signed [31:0] last_output_reg, last_output_next;

    // Working registers
    logic signed [31:0] clamped_reg, clamped_next;
    logic signed [31:0] outv_reg;
    logic               changed_reg;
    logic signed [63:0] p_off_reg, p_adj_reg;
    logic signed [63:0] num_reg, num_next;
    logic signed [63:0] den_reg, den_next;
    logic        [63:0] n_reg, d_reg;
    logic               neg_reg, ovf_reg;
    logic        [63:0] r_reg, r_next;
    logic [DivBits-1:0] nsh_reg, q_reg;
    logic        [40:0] qm_reg, qm_next;

    // Result registers
    logic signed [31:0] clamped_o_reg, outv_o_reg, raw_o_reg, raw_next;
    logic               changed_o_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_high_reg <= '0;
            drive_low_reg  <= '0;
            rate_limit_reg <= '0;
            eng_slope_reg  <= QOne;
            eng_offset_reg <= '0;
            adj_slope_reg  <= '0;
            adj_offset_reg <= '0;
            raw_offset_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DRIVE_HIGH: drive_high_reg <= cfg_data;
                CFG_DRIVE_LOW:  drive_low_reg  <= cfg_data;
                CFG_RATE_LIMIT: rate_limit_reg <= cfg_data[30:0];
                CFG_ENG_SLOPE:  eng_slope_reg  <= cfg_data;
                CFG_ENG_OFFSET: eng_offset_reg <= cfg_data;
                CFG_ADJ_SLOPE:  adj_slope_reg  <= cfg_data;
                CFG_ADJ_OFFSET: adj_offset_reg <= cfg_data;
                CFG_RAW_OFFSET: raw_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp to drive limits when they are ordered
    always_comb begin
        clamped_next = signed'(set_value);
        if (drive_high_reg > drive_low_reg) begin
            if (clamped_next > drive_high_reg) begin
                clamped_next = drive_high_reg;
            end else if (clamped_next < drive_low_reg) begin
                clamped_next = drive_low_reg;
            end
        end
    end

    // Slew limit toward the clamped value
    logic signed [32:0] diff, rate33, outv33;
    always_comb begin
        diff   = {clamped_reg[31], clamped_reg} - {last_output_reg[31], last_output_reg};
        rate33 = {2'b00, rate_limit_reg};
        outv33 = {clamped_reg[31], clamped_reg};
        if (rate_limit_reg != '0) begin
            if (diff < 0) begin
                if (rate33 < -diff) begin
                    outv33 = {last_output_reg[31], last_output_reg} - rate33;
                end
            end else if (rate33 < diff) begin
                outv33 = {last_output_reg[31], last_output_reg} + rate33;
            end
        end
        last_output_next = outv33[31:0];
    end

    // Kept output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_output_reg <= '0;
        end else if (cmd.slew) begin
            last_output_reg <= last_output_next;
        end
    end

    // Shared 32x32 multiplier, eng_slope times the selected operand
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    assign mul_b = cmd.mul_adj ? adj_slope_reg : adj_offset_reg;
    assign prod  = eng_slope_reg * mul_b;

    // Exact ratio num / den of the value to be rounded
    logic signed [32:0] xdiff;
    always_comb begin
        xdiff = {outv_reg[31], outv_reg} - {eng_offset_reg[31], eng_offset_reg};
        if (eng_slope_reg != '0) begin
            num_next = {{15{xdiff[32]}}, xdiff, 16'b0} - p_off_reg;
            den_next = (adj_slope_reg != '0) ? p_adj_reg
                     : {{16{eng_slope_reg[31]}}, eng_slope_reg, 16'b0};
        end else begin
            num_next = 64'sd0 - {{32{adj_offset_reg[31]}}, adj_offset_reg};
            den_next = (adj_slope_reg != '0) ? {{32{adj_slope_reg[31]}}, adj_slope_reg}
                     : {{32{QOne[31]}}, QOne};
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    logic [63:0] trial;
    logic        fits;
    always_comb begin
        trial  = {r_reg[62:0], nsh_reg[DivBits-1]};
        fits   = (trial >= d_reg);
        r_next = fits ? (trial - d_reg) : trial;
    end

    // Round half away from zero, cap magnitude at 2^40
    logic              up;
    logic [DivBits:0]  q_rnd;
    always_comb begin
        up    = (r_reg >= (d_reg - r_reg));
        q_rnd = {1'b0, q_reg} + {{DivBits{1'b0}}, up};
        if (ovf_reg || (q_rnd > {{(DivBits - 40){1'b0}}, QMax})) begin
            qm_next = QMax;
        end else begin
            qm_next = q_rnd[40:0];
        end
    end

    // Apply sign, subtract raw offset, saturate to 32 bits
    logic signed [42:0] q_ext, q_sgn, raw43;
    always_comb begin
        q_ext = {2'b00, qm_reg};
        q_sgn = neg_reg ? (43'sd0 - q_ext) : q_ext;
        raw43 = q_sgn - {{11{raw_offset_reg[31]}}, raw_offset_reg};
        if (raw43 > RawMax) begin
            raw_next = RawMax[31:0];
        end else if (raw43 < RawMin) begin
            raw_next = RawMin[31:0];
        end else begin
            raw_next = raw43[31:0];
        end
    end

    // Working registers, stepped by command
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            clamped_reg <= clamped_next;
        end
        if (cmd.slew) begin
            outv_reg    <= last_output_next;
            changed_reg <= (last_output_next != last_output_reg);
        end
        if (cmd.mul_off) begin
            p_off_reg <= prod;
        end
        if (cmd.mul_adj) begin
            p_adj_reg <= prod;
        end
        if (cmd.prep) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        if (cmd.mag) begin
            n_reg   <= num_reg[63] ? (64'd0 - num_reg) : num_reg;
            d_reg   <= den_reg[63] ? (64'd0 - den_reg) : den_reg;
            neg_reg <= num_reg[63] ^ den_reg[63];
        end
        if (cmd.check) begin
            // quotient of 2^42 or more always ends at the cap
            ovf_reg <= ({{DivBits{1'b0}}, n_reg} >= {d_reg, {DivBits{1'b0}}});
            r_reg   <= {{DivBits{1'b0}}, n_reg[63:DivBits]};
            nsh_reg <= n_reg[DivBits-1:0];
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            r_reg   <= r_next;
            nsh_reg <= {nsh_reg[DivBits-2:0], 1'b0};
            q_reg   <= {q_reg[DivBits-2:0], fits};
        end
        if (cmd.round) begin
            qm_reg <= qm_next;
        end
        if (cmd.load_out) begin
            clamped_o_reg <= clamped_reg;
            outv_o_reg    <= outv_reg;
            changed_o_reg <= changed_reg;
            raw_o_reg     <= raw_next;
        end
    end

    assign clamped_value  = clamped_o_reg;
    assign output_value   = outv_o_reg;
    assign output_changed = changed_o_reg;
    assign raw_value      = raw_o_reg;

    // Partial remainder stays below the divisor while dividing in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && !ovf_reg) |-> (r_reg < d_reg))
        else $error("divider remainder not below divisor");

    // Rounded magnitude never exceeds the cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round |=> (qm_reg <= QMax))
        else $error("rounded magnitude above cap");

    // The slewed output stays between the kept output and the clamped target
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.slew |-> ((last_output_next >= last_output_reg && last_output_next <= clamped_reg)
                   || (last_output_next <= last_output_reg && last_output_next >= clamped_reg)))
        else $error("slewed output overshoots target");

endmodule

`default_nettype wire

// ===== rtl/setpoint_clamp_slew_raw_convert_unit.sv =====
// Setpoint clamp, slew limit and raw conversion unit, top level.
// Instantiates scsr_ctrl and scsr_dp; uses scsr_pkg.
//
// Usage:
//   s_ channel: one Q16.16 setpoint per transfer on s_tdata.
//   m_ channel: one result per setpoint: clamped, rate-limited and raw values
//     on m_tdata, the output-changed flag on m_tuser.
//   cfg channel: register writes, always ready; write only while the unit is
//     idle (all results taken).
// Timing: one item at a time; a new setpoint is taken only once the last
//   result is loaded, and the input reopens in the same cycle that result
//   raises m_tvalid. Processing time is set by the restoring divider, one
//   quotient bit per cycle over 42 bits, plus clamp, slew, two passes of the
//   shared multiplier and rounding steps.
// Reset: aresetn low clears the registers to their defaults (eng_slope 1.0,
//   others 0), the kept output to 0, and drops m_tvalid.
// Stall: a held result stays on m_ while the next item is accepted and
//   processed; that item waits in the datapath until the slot drains.
`default_nettype none

module setpoint_clamp_slew_raw_convert_unit
    import scsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // setpoint input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] set_value
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,    // [31:0] clamped_value, [63:32] output_value,
                                         // [95:64] raw_value
    output logic             m_tuser,    // [0] output_changed
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmd_t        cmd;
    logic [31:0] clamped_value, output_value, raw_value;
    logic        output_changed;

    assign cfg_ready = 1'b1;

    scsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    scsr_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .set_value      (s_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .clamped_value  (clamped_value),
        .output_value   (output_value),
        .output_changed (output_changed),
        .raw_value      (raw_value)
    );

    assign m_tdata = {raw_value, output_value, clamped_value};
    assign m_tuser = output_changed;

endmodule

`default_nettype wire
